### hdl/udpdht_pkg.sv
// Shared types and widths for the UDP DHT/uTP/BT-SEARCH flow classifier.
// No dependencies; the other files that use it refer to this package by scoped names.
package udpdht_pkg;

  localparam int unsigned HEAD_W = 32;
  localparam int unsigned LEN_W  = 16;

  typedef logic [HEAD_W-1:0] head_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    head_t head_a;
    len_t  length_a;
    head_t head_b;
    len_t  length_b;
  } item_t;

endpackage

### hdl/udpdht_in_if.sv
// Input channel of the flow classifier: one flow record per beat.
// Depends on udpdht_pkg for field types.
interface udpdht_in_if;
  logic               valid;
  logic               ready;
  udpdht_pkg::head_t  head_a;
  udpdht_pkg::len_t   length_a;
  udpdht_pkg::head_t  head_b;
  udpdht_pkg::len_t   length_b;

  modport source (output valid, head_a, length_a, head_b, length_b, input ready);
  modport sink   (input valid, head_a, length_a, head_b, length_b, output ready);
endinterface

### hdl/udpdht_out_if.sv
// Result channel of the flow classifier: one match flag per beat.
// No dependencies.
interface udpdht_out_if;
  logic valid;
  logic ready;
  logic is_match;

  modport source (output valid, is_match, input ready);
  modport sink   (input valid, is_match, output ready);
endinterface

### hdl/udpdht_classify.sv
// Combinational DHT/uTP/BT-SEARCH decision for one registered flow record.
// Depends on udpdht_pkg for the record type.
module udpdht_classify (
  input  udpdht_pkg::item_t item,
  output logic              is_match
);

  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_1     = 8'h31;  // '1'
  localparam logic [7:0] CH_2     = 8'h32;  // '2'
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] UTP_01   = 8'h01;
  localparam logic [7:0] UTP_11   = 8'h11;
  localparam logic [7:0] UTP_21   = 8'h21;
  localparam logic [7:0] UTP_31   = 8'h31;
  localparam logic [7:0] UTP_41   = 8'h41;
  localparam logic [7:0] SUB_00   = 8'h00;
  localparam logic [7:0] SUB_01   = 8'h01;
  localparam logic [7:0] SUB_02   = 8'h02;
  localparam udpdht_pkg::head_t BT_SEARCH = 32'h42_54_2d_53;  // "BT-S"
  localparam udpdht_pkg::len_t  LEN_0  = 16'd0;
  localparam udpdht_pkg::len_t  LEN_20 = 16'd20;
  localparam udpdht_pkg::len_t  LEN_23 = 16'd23;
  localparam udpdht_pkg::len_t  LEN_26 = 16'd26;
  localparam udpdht_pkg::len_t  LEN_30 = 16'd30;
  localparam udpdht_pkg::len_t  LEN_33 = 16'd33;

  function automatic logic pair(udpdht_pkg::head_t h, logic [7:0] x, logic [7:0] y);
    return (h[31:24] == x) && (h[23:16] == y);
  endfunction

  function automatic logic utp_query(udpdht_pkg::head_t h, udpdht_pkg::len_t n);
    logic [7:0] t;
    logic [7:0] s;
    logic       fam;
    t   = h[31:24];
    s   = h[23:16];
    fam = (t == UTP_11) || (t == UTP_21) || (t == UTP_31) || (t == UTP_41);
    return ((t == UTP_01) && (s == SUB_00)) ||
           (fam && (s == SUB_00) && (n == LEN_20)) ||
           (fam && (t != UTP_11) && (s == SUB_02) && (n == LEN_30));
  endfunction

  function automatic logic utp_reply(udpdht_pkg::head_t h, udpdht_pkg::len_t n);
    return (n == LEN_0) ||
           (pair(h, UTP_11, SUB_00) && (n == LEN_20)) ||
           (pair(h, UTP_21, SUB_02) && ((n == LEN_30) || (n == LEN_33))) ||
           (pair(h, UTP_21, SUB_01) && ((n == LEN_26) || (n == LEN_23))) ||
           (pair(h, UTP_21, SUB_00) && (n == LEN_20)) ||
           (pair(h, UTP_31, SUB_02) && (n == LEN_30)) ||
           (pair(h, UTP_31, SUB_00) && (n == LEN_20)) ||
           (pair(h, UTP_41, SUB_00) && (n == LEN_20)) ||
           (pair(h, UTP_41, SUB_02) && ((n == LEN_33) || (n == LEN_30)));
  endfunction

  function automatic logic dict_query(udpdht_pkg::head_t h);
    logic [7:0] c2;
    logic [7:0] c3;
    c2 = h[15:8];
    c3 = h[7:0];
    return pair(h, CH_D, CH_1) &&
           (((c2 == CH_COLON) && ((c3 == CH_A) || (c3 == CH_R) || (c3 == CH_E) ||
                                   (c3 == CH_Q) || (c3 == CH_T))) ||
            (c3 == CH_COLON));
  endfunction

  function automatic logic dict_reply(udpdht_pkg::head_t h, udpdht_pkg::len_t n);
    logic [7:0] c2;
    logic [7:0] c3;
    c2 = h[15:8];
    c3 = h[7:0];
    return (n == LEN_0) ||
           (pair(h, CH_D, CH_1) &&
            (((c2 == CH_COLON) && ((c3 == CH_A) || (c3 == CH_R) || (c3 == CH_E))) ||
             (c3 == CH_COLON))) ||
           (pair(h, CH_D, CH_2) && (c2 == CH_COLON) && (c3 == CH_I)) ||
           (n == LEN_23) || (n == LEN_33);
  endfunction

  // Sequence tolerance of one, no wrap: compare at 17 bits.
  function automatic logic seq_close(udpdht_pkg::head_t q, udpdht_pkg::head_t r);
    logic [16:0] qs;
    logic [16:0] rs;
    qs = {1'b0, q[15:0]};
    rs = {1'b0, r[15:0]};
    return (qs == rs) || (qs == rs + 17'd1) || (qs + 17'd1 == rs);
  endfunction

  logic dq_a, dq_b, dr_a, dr_b, uq_a, uq_b, ur_a, ur_b;
  logic seq_fail_a, seq_fail_b;

  always_comb begin
    dq_a = dict_query(item.head_a);
    dq_b = dict_query(item.head_b);
    dr_a = dict_reply(item.head_a, item.length_a);
    dr_b = dict_reply(item.head_b, item.length_b);
    uq_a = utp_query(item.head_a, item.length_a);
    uq_b = utp_query(item.head_b, item.length_b);
    ur_a = utp_reply(item.head_a, item.length_a);
    ur_b = utp_reply(item.head_b, item.length_b);
    seq_fail_a = pair(item.head_a, UTP_01, SUB_00) && !seq_close(item.head_a, item.head_b);
    seq_fail_b = pair(item.head_b, UTP_01, SUB_00) && !seq_close(item.head_b, item.head_a);

    if (dq_a && (dr_b || ur_b || uq_b)) begin
      is_match = 1'b1;
    end else if (dq_b && (dr_a || ur_a || uq_a)) begin
      is_match = 1'b1;
    end else if (uq_a && seq_fail_a) begin
      is_match = 1'b0;
    end else if (uq_a && (ur_b || dr_b)) begin
      is_match = 1'b1;
    end else if (uq_b && seq_fail_b) begin
      is_match = 1'b0;
    end else if (uq_b && (ur_a || dr_a)) begin
      is_match = 1'b1;
    end else begin
      is_match = ((item.head_a == BT_SEARCH) && (item.length_b == LEN_0)) ||
                 ((item.head_b == BT_SEARCH) && (item.length_a == LEN_0));
    end
  end

endmodule

### hdl/udp_dht_flow_classifier_core.sv
// Top level of the UDP flow classifier: input register, decision logic, result register.
// Depends on udpdht_pkg, udpdht_in_if, udpdht_out_if and udpdht_classify.
//
//   channel   | dir | beat contents
//   in_chan   | in  | head_a, length_a, head_b, length_b
//   out_chan  | out | is_match
//
// One flow record per cycle while the result is not stalled; each record passes both stages.
// The path runs input register -> byte compares -> result register.
// rst_n (synchronous) empties both stages; payload registers are not reset.
// A stalled result holds; the input register still refills as the result leaves,
// so in_chan.ready drops only when both stages are full and out_chan.ready is low.
module udp_dht_flow_classifier_core (
  input  logic          clk,
  input  logic          rst_n,
  udpdht_in_if.sink     in_chan,
  udpdht_out_if.source  out_chan
);

  logic              s1_valid_r, s1_valid_nxt;
  udpdht_pkg::item_t s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_match_r;
  logic              match;
  logic              s2_ready;
  logic              s1_ready;

  assign s2_ready = !out_valid_r || out_chan.ready;
  assign s1_ready = !s1_valid_r || s2_ready;

  assign in_chan.ready   = s1_ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.is_match = out_match_r;

  udpdht_classify u_classify (
    .item     (s1_item_r),
    .is_match (match)
  );

  always_comb begin
    s1_valid_nxt  = s1_ready ? in_chan.valid : s1_valid_r;
    out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      s1_item_r.head_a   <= in_chan.head_a;
      s1_item_r.length_a <= in_chan.length_a;
      s1_item_r.head_b   <= in_chan.head_b;
      s1_item_r.length_b <= in_chan.length_b;
    end
    if (s2_ready && s1_valid_r) begin
      out_match_r <= match;
    end
  end

endmodule

### hdl/udpdht_check.sv
// Port-level checks for udp_dht_flow_classifier_core, attached by bind.
// Depends on the top level's channel interfaces.
module udpdht_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_match
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_match))
    else $error("stalled result beat changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with result slot empty");

  a_new_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without input beat two cycles earlier");

endmodule

bind udp_dht_flow_classifier_core udpdht_check u_udpdht_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_is_match (out_chan.is_match)
);
